>>> rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

    // Managed byte space and the field widths that follow from it
    localparam int SPACE_BYTES    = 4096;
    localparam int ADDR_W         = $clog2(SPACE_BYTES);
    localparam int SIZE_W         = $clog2(SPACE_BYTES + 1);
    localparam int SLOT_COUNT_DEF = 64;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ROOM,
        ST_FREE,
        ST_DONE
    } state_t;

    // Input transfer
    typedef struct packed {
        op_t               operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    // Result transfer
    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic              success;
        logic [SIZE_W-1:0] bytes_in_use;
    } rsp_t;

    // One entry of the slot table
    typedef struct packed {
        logic              live;
        logic [SIZE_W-1:0] length;
        logic [ADDR_W-1:0] start;
    } slot_t;

endpackage

>>> rtl/first_fit_block_allocator.sv
// First-fit block allocator: top level with slot sequencer and result register.
//
// Manages a byte space of SPACE_BYTES bytes through a table of SLOT_COUNT
// slots held in one RAM. An allocate walks the table one slot per cycle,
// tracking a candidate start that follows the end of each live slot; at the
// first empty slot for a new candidate, a room scan passes over the whole
// table (one slot per cycle, through the same read port and one shared
// compare/subtract unit) to find the gap up to the nearest live block. A
// free walks the table once and releases every live slot with a matching
// start. Each transfer in gets exactly one result transfer out, reporting
// the bytes in use afterwards. A free makes one pass over the table; an
// allocate walks the table and runs one room scan per distinct candidate
// reached; a size-zero or oversized request skips the table and goes
// straight to the result. The single RAM read port sets the pace. After
// reset the table is cleared in a pass over every slot during which no
// input is accepted. The result register lets the next input be taken
// while a result still waits on the output side.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_W = $bits(slot_t);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] rel_reg, rel_next;
    logic [SIZE_W-1:0] cand_reg, cand_next;
    logic              checked_reg, checked_next;
    logic [IDX_W-1:0]  target_reg, target_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [SIZE_W-1:0] room_reg, room_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_ok_reg, res_ok_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              m_data_reg, m_data_next;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_t             ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             rd_slot;

    // Shared datapath
    logic [SIZE_W:0]   slot_end;
    logic [SIZE_W-1:0] gap;
    logic [SIZE_W-1:0] room_upd;
    logic [SIZE_W-1:0] free_total;
    logic              last_rd;
    logic              out_free;
    logic              scanning;
    logic              issue;
    logic              bad_req;
    logic              fits;

    ffba_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_slot = slot_t'(ram_rdata);

    // One adder for slot end, subtracts for gap and free total
    assign slot_end   = (SIZE_W + 1)'(rd_slot.start) + (SIZE_W + 1)'(rd_slot.length);
    assign gap        = SIZE_W'(rd_slot.start) - cand_reg;
    assign free_total = (used_reg < SIZE_W'(SPACE_BYTES)) ?
                        SIZE_W'(SPACE_BYTES) - used_reg : '0;

    // Room update for one scanned slot
    always_comb begin
        room_upd = room_reg;
        if (rd_slot.live) begin
            if (SIZE_W'(rd_slot.start) >= cand_reg) begin
                if (gap < room_reg) begin
                    room_upd = gap;
                end
            end else if (slot_end > (SIZE_W + 1)'(cand_reg)) begin
                room_upd = '0;
            end
        end
    end

    assign last_rd  = rd_vld_reg && (rd_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign bad_req  = (s_data.request_size == '0) || (s_data.request_size > free_total);
    assign fits     = (room_upd >= size_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (issue_reg == CNT_W'(SLOT_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == OP_FREE) begin
                        state_next = ST_FREE;
                    end else if (bad_req) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (rd_vld_reg) begin
                    if (!rd_slot.live && !checked_reg) begin
                        state_next = ST_ROOM;
                    end else if (last_rd) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROOM: begin
                if (last_rd) begin
                    if (fits || target_reg == IDX_W'(SLOT_COUNT - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_FREE: begin
                if (last_rd) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        size_next     = size_reg;
        rel_next      = rel_reg;
        cand_next     = cand_reg;
        checked_next  = checked_reg;
        target_next   = target_reg;
        issue_next    = issue_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        room_next     = room_reg;
        used_next     = used_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = rd_idx_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = issue_reg[IDX_W-1:0];

        // Table reads stream one slot per cycle while a scan stays put
        scanning = (state_reg == ST_WALK) || (state_reg == ST_ROOM) || (state_reg == ST_FREE);
        issue    = scanning && (issue_reg < CNT_W'(SLOT_COUNT)) && (state_next == state_reg);
        if (issue) begin
            ram_re      = 1'b1;
            rd_vld_next = 1'b1;
            rd_idx_next = issue_reg[IDX_W-1:0];
            issue_next  = issue_reg + CNT_W'(1);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = issue_reg[IDX_W-1:0];
                issue_next = issue_reg + CNT_W'(1);
                if (state_next == ST_IDLE) begin
                    issue_next = '0;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    size_next     = s_data.request_size;
                    rel_next      = s_data.release_address;
                    cand_next     = '0;
                    checked_next  = 1'b0;
                    issue_next    = '0;
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                end
            end
            ST_WALK: begin
                if (rd_vld_reg) begin
                    if (rd_slot.live) begin
                        cand_next    = SIZE_W'(slot_end);
                        checked_next = 1'b0;
                    end else if (!checked_reg) begin
                        // New candidate: measure its room over the whole table
                        target_next = rd_idx_reg;
                        room_next   = SIZE_W'(SPACE_BYTES) - cand_reg;
                        issue_next  = '0;
                    end
                end
            end
            ST_ROOM: begin
                if (rd_vld_reg) begin
                    room_next = room_upd;
                    if (last_rd) begin
                        if (fits) begin
                            ram_we           = 1'b1;
                            ram_waddr        = target_reg;
                            ram_wdata.live   = 1'b1;
                            ram_wdata.length = size_reg;
                            ram_wdata.start  = cand_reg[ADDR_W-1:0];
                            used_next        = used_reg + size_reg;
                            res_addr_next    = cand_reg[ADDR_W-1:0];
                            res_ok_next      = 1'b1;
                        end else begin
                            // Resume the walk after the slot that did not fit
                            checked_next = 1'b1;
                            issue_next   = CNT_W'(target_reg) + CNT_W'(1);
                        end
                    end
                end
            end
            ST_FREE: begin
                if (rd_vld_reg && rd_slot.live && rd_slot.start == rel_reg) begin
                    ram_we          = 1'b1;
                    ram_waddr       = rd_idx_reg;
                    ram_wdata.start = rd_slot.start;
                    used_next       = (used_reg >= rd_slot.length) ?
                                      used_reg - rd_slot.length : '0;
                    res_ok_next     = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.granted_address = res_addr_reg;
                    m_data_next.success         = res_ok_reg;
                    m_data_next.bytes_in_use    = used_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        size_reg     <= size_next;
        rel_reg      <= rel_next;
        cand_reg     <= cand_next;
        checked_reg  <= checked_next;
        target_reg   <= target_next;
        rd_idx_reg   <= rd_idx_next;
        room_reg     <= room_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
